>>> hdl/sbds_pkg.sv
// Package for the SPI baud divider search: codes, divider tables and shared types.
package sbds_pkg;

  localparam int unsigned RateWidth  = 32;
  localparam int unsigned DivWidth   = 19;
  localparam int unsigned ProdWidth  = RateWidth + DivWidth;

  localparam logic [2:0] PRESCALERS [4] = '{3'd2, 3'd3, 3'd5, 3'd7};

  localparam logic [15:0] SCALERS [16] = '{
    16'd2,    16'd4,    16'd6,    16'd8,
    16'd16,   16'd32,   16'd64,   16'd128,
    16'd256,  16'd512,  16'd1024, 16'd2048,
    16'd4096, 16'd8192, 16'd16384, 16'd32768
  };

  typedef enum logic [1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic       valid;
    logic [1:0] p_idx;
    logic [3:0] s_idx;
    logic       last;
  } issue_t;

  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [1:0] p_idx;
    logic [3:0] s_idx;
    logic       last;
  } match_t;

  function automatic logic [DivWidth-1:0] sbds_divisor(input logic [1:0] p_idx,
                                                       input logic [3:0] s_idx,
                                                       input logic       dbl);
    logic [2:0]          pre;
    logic [15:0]         scl;
    logic [DivWidth-1:0] base;
    pre  = PRESCALERS[p_idx];
    scl  = SCALERS[s_idx];
    base = DivWidth'(pre) * DivWidth'(scl);
    return base << dbl;
  endfunction

endpackage

>>> hdl/sbds_match_unit.sv
// Shared multiply and range-compare unit testing one divider pair per cycle.
module sbds_match_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbds_pkg::issue_t    issue_i,
  input  logic                double_rate_i,
  input  logic [31:0]         requested_rate_i,
  input  logic [31:0]         clock_frequency_i,
  output sbds_pkg::match_t    match_o
);
  import sbds_pkg::*;

  logic [DivWidth-1:0]  div_d, div_q;
  logic [ProdWidth-1:0] prod_d, prod_q;
  logic                 valid_q;
  logic [1:0]           p_idx_q;
  logic [3:0]           s_idx_q;
  logic                 last_q;
  logic [ProdWidth:0]   diff;

  assign div_d  = sbds_divisor(issue_i.p_idx, issue_i.s_idx, double_rate_i);
  assign prod_d = ProdWidth'(requested_rate_i) * ProdWidth'(div_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    prod_q  <= prod_d;
    p_idx_q <= issue_i.p_idx;
    s_idx_q <= issue_i.s_idx;
    last_q  <= issue_i.last;
  end

  // hit when request * div <= clock < (request + 1) * div
  assign diff = (ProdWidth + 1)'(clock_frequency_i) - {1'b0, prod_q};

  always_comb begin
    match_o.valid = valid_q;
    match_o.hit   = valid_q && !diff[ProdWidth]
                    && (diff[ProdWidth-1:0] < ProdWidth'(div_q));
    match_o.p_idx = p_idx_q;
    match_o.s_idx = s_idx_q;
    match_o.last  = last_q;
  end

endmodule

>>> hdl/spi_baud_divider_search_core.sv
// Top level of the SPI baud divider search: sequencer, configuration and result registers.
//
// Usage:
//   Write the input clock frequency on clock_frequency_i with cfg_valid_i;
//   cfg_ready_o is always high, and writes belong to idle periods only.
//   A requested rate is taken at a rising edge with start high and busy low.
//   busy stays high while the search runs. One word of result is shown on
//   status_o, double_rate_o, prescaler_index_o and scaler_index_o for exactly
//   one cycle with done_o high; the receiver cannot stall it.
//   A zero request gives its result in the cycle after acceptance.
//   Otherwise the sequencer issues divider pairs in order, prescaler outer,
//   scaler inner, one pair per cycle into the shared multiplier; the compare
//   follows in the cycle after. A match at pair k (0 to 63) is reported once
//   it passes the match unit registers and the done register; no match is
//   reported after the last pair is compared. No new request is taken while
//   busy, but a new one may be started in the cycle that done_o is high.
//   Reset clears the clock frequency to zero and returns the block to idle.
module spi_baud_divider_search_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] requested_rate_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] clock_frequency_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        double_rate_o,
  output logic [1:0]  prescaler_index_o,
  output logic [3:0]  scaler_index_o
);
  import sbds_pkg::*;

  state_e      state_d, state_q;
  logic [31:0] clk_freq_q;
  logic [31:0] req_d, req_q;
  logic        dbl_d, dbl_q;
  logic [5:0]  idx_d, idx_q;
  logic        issued_all_d, issued_all_q;
  logic        done_d, done_q;
  status_e     status_d, status_q;
  logic        dbl_out_d, dbl_out_q;
  logic [1:0]  p_out_d, p_out_q;
  logic [3:0]  s_out_d, s_out_q;
  logic        accept;
  issue_t      issue;
  match_t      match;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q == ST_SEARCH);
  assign accept      = start && !busy;

  sbds_match_unit u_match (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .issue_i           (issue),
    .double_rate_i     (dbl_q),
    .requested_rate_i  (req_q),
    .clock_frequency_i (clk_freq_q),
    .match_o           (match)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (requested_rate_i != 32'd0)) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (match.valid && (match.hit || match.last)) state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_d        = req_q;
    dbl_d        = dbl_q;
    idx_d        = idx_q;
    issued_all_d = issued_all_q;
    done_d       = 1'b0;
    status_d     = status_q;
    dbl_out_d    = dbl_out_q;
    p_out_d      = p_out_q;
    s_out_d      = s_out_q;
    issue.valid  = 1'b0;
    issue.p_idx  = idx_q[5:4];
    issue.s_idx  = idx_q[3:0];
    issue.last   = (idx_q == 6'h3f);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d        = requested_rate_i;
          dbl_d        = requested_rate_i > (clk_freq_q >> 2);
          idx_d        = 6'd0;
          issued_all_d = 1'b0;
          if (requested_rate_i == 32'd0) begin
            done_d    = 1'b1;
            status_d  = STATUS_INVALID;
            dbl_out_d = 1'b0;
            p_out_d   = 2'd0;
            s_out_d   = 4'd0;
          end
        end
      end
      ST_SEARCH: begin
        issue.valid = !issued_all_q;
        if (!issued_all_q) begin
          if (idx_q == 6'h3f) issued_all_d = 1'b1;
          else idx_d = idx_q + 6'd1;
        end
        if (match.valid && match.hit) begin
          done_d    = 1'b1;
          status_d  = STATUS_FOUND;
          dbl_out_d = dbl_q;
          p_out_d   = match.p_idx;
          s_out_d   = match.s_idx;
        end else if (match.valid && match.last) begin
          done_d    = 1'b1;
          status_d  = STATUS_NO_MATCH;
          dbl_out_d = 1'b0;
          p_out_d   = 2'd0;
          s_out_d   = 4'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clk_freq_q   <= 32'd0;
      idx_q        <= 6'd0;
      issued_all_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      issued_all_q <= issued_all_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) clk_freq_q <= clock_frequency_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    dbl_q     <= dbl_d;
    status_q  <= status_d;
    dbl_out_q <= dbl_out_d;
    p_out_q   <= p_out_d;
    s_out_q   <= s_out_d;
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign double_rate_o     = dbl_out_q;
  assign prescaler_index_o = p_out_q;
  assign scaler_index_o    = s_out_q;

`ifndef NO_ASSERTIONS
  a_zero_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (requested_rate_i == 32'd0) |=> done_o && (status_o == STATUS_INVALID))
    else $error("zero request not reported as invalid");

  a_search_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (requested_rate_i != 32'd0) |=> busy && !done_o)
    else $error("search did not start");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still searching");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STATUS_FOUND)
      |-> !double_rate_o && (prescaler_index_o == 2'd0) && (scaler_index_o == 4'd0))
    else $error("failure result carries nonzero divider fields");
`endif

endmodule

>>> test/spi_baud_divider_search_core_tb.sv
// Self-checking testbench for the SPI baud divider search core with a built-in divider search.
module spi_baud_divider_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbds_pkg::*;

  typedef enum logic [1:0] {
    KIND_RATE,
    KIND_CLOCK,
    KIND_DRAIN
  } word_kind_e;

  typedef struct packed {
    word_kind_e  kind;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    status_e    status;
    logic       double_rate;
    logic [1:0] prescaler_index;
    logic [3:0] scaler_index;
  } divider_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start             = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic [31:0] requested_rate_i  = '0;
  logic [31:0] clock_frequency_i = '0;
  logic        busy;
  logic        cfg_ready_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic        double_rate_o;
  logic [1:0]  prescaler_index_o;
  logic [3:0]  scaler_index_o;

  request_t    request_q[$];
  divider_t    expected_divider_q[$];
  logic [31:0] clock_model   = '0;
  int          outstanding   = 0;
  int          idle_left     = 0;
  bit          no_idle       = 1'b0;
  int          errors        = 0;
  int          rates_sent    = 0;
  int          clock_writes  = 0;
  int          found_cnt     = 0;
  int          invalid_cnt   = 0;
  int          no_match_cnt  = 0;

  spi_baud_divider_search_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .requested_rate_i  (requested_rate_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .clock_frequency_i (clock_frequency_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .double_rate_o     (double_rate_o),
    .prescaler_index_o (prescaler_index_o),
    .scaler_index_o    (scaler_index_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned prescale_of(input int idx);
    case (idx)
      0:       return 64'd2;
      1:       return 64'd3;
      2:       return 64'd5;
      default: return 64'd7;
    endcase
  endfunction

  function automatic longint unsigned scale_of(input int idx);
    if (idx < 4) return 64'(2 * (idx + 1));
    return 64'd1 << idx;
  endfunction

  function automatic divider_t search_divider(input logic [31:0] clk_hz, input logic [31:0] rate);
    divider_t          res;
    longint unsigned   clk64;
    longint unsigned   req64;
    longint unsigned   factor;
    longint unsigned   base;
    bit                hit;
    res        = '0;
    res.status = STATUS_NO_MATCH;
    hit        = 1'b0;
    clk64      = clk_hz;
    req64      = rate;
    if (rate == 32'd0) begin
      res.status = STATUS_INVALID;
    end else begin
      factor = (req64 > clk64 / 4) ? 64'd2 : 64'd1;
      for (int p = 0; p < 4; p++) begin
        base = clk64 / (prescale_of(p) * factor);
        for (int s = 0; s < 16; s++) begin
          if (!hit && (base / scale_of(s) == req64)) begin
            hit                 = 1'b1;
            res.status          = STATUS_FOUND;
            res.double_rate     = (factor == 64'd2);
            res.prescaler_index = p[1:0];
            res.scaler_index    = s[3:0];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic logic [31:0] pick_rate(input logic [31:0] clk_hz);
    longint unsigned hit_rate;
    int              r;
    r        = $urandom_range(0, 99);
    hit_rate = 64'(clk_hz) / (prescale_of($urandom_range(0, 3)) * $urandom_range(1, 2))
               / scale_of($urandom_range(0, 15));
    if (r < 55) return hit_rate[31:0];
    if (r < 65) return ($urandom_range(0, 1)) ? hit_rate[31:0] + 32'd1 : hit_rate[31:0] - 32'd1;
    if (r < 70) return 32'd0;
    if (r < 85) return $urandom;
    return $urandom_range(1, 1000);
  endfunction

  task automatic queue_word(input word_kind_e kind, input logic [31:0] value);
    request_t w;
    w.kind  = kind;
    w.value = value;
    request_q.push_back(w);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : driver
    request_t head;
    logic     start_n;
    logic     cfg_n;
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      start_n = start;
      cfg_n   = cfg_valid_i;
      if (done_o === 1'b1) outstanding--;
      if (start && busy === 1'b0) begin
        expected_divider_q.push_back(search_divider(clock_model, requested_rate_i));
        outstanding++;
        rates_sent++;
        start_n = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o === 1'b1) begin
        clock_model = clock_frequency_i;
        clock_writes++;
        cfg_n = 1'b0;
      end
      if (!start_n && !cfg_n) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (request_q.size() > 0) begin
          head = request_q[0];
          case (head.kind)
            KIND_RATE: begin
              start_n = 1'b1;
              requested_rate_i <= head.value;
              void'(request_q.pop_front());
              idle_left = pick_gap();
            end
            KIND_CLOCK: begin
              if (outstanding == 0) begin
                cfg_n = 1'b1;
                clock_frequency_i <= head.value;
                void'(request_q.pop_front());
                idle_left = pick_gap();
              end
            end
            default: begin
              if (outstanding == 0) void'(request_q.pop_front());
            end
          endcase
        end
      end
      start       <= start_n;
      cfg_valid_i <= cfg_n;
    end
  end

  always @(posedge clk_i) begin : monitor
    divider_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_divider_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result word, expected none, actual status %0d",
                 $time, status_o);
      end else begin
        want = expected_divider_q.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("double_rate", 32'(want.double_rate), 32'(double_rate_o));
        check_field("prescaler_index", 32'(want.prescaler_index), 32'(prescaler_index_o));
        check_field("scaler_index", 32'(want.scaler_index), 32'(scaler_index_o));
        case (want.status)
          STATUS_FOUND:   found_cnt++;
          STATUS_INVALID: invalid_cnt++;
          default:        no_match_cnt++;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [31:0] clk_set;
    int          n;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // hold clock at its reset value of zero
    queue_word(KIND_RATE, 32'd0);
    queue_word(KIND_RATE, 32'd1);
    queue_word(KIND_RATE, 32'hFFFF_FFFF);
    queue_word(KIND_RATE, 32'h8000_0000);
    queue_word(KIND_CLOCK, 32'd4);
    queue_word(KIND_RATE, 32'd1);
    queue_word(KIND_RATE, 32'd2);
    queue_word(KIND_CLOCK, 32'hFFFF_FFFF);
    queue_word(KIND_RATE, 32'd0);
    queue_word(KIND_RATE, 32'h3FFF_FFFF);
    queue_word(KIND_RATE, 32'h4000_0000);
    queue_word(KIND_RATE, 32'h1FFF_FFFF);
    queue_word(KIND_RATE, 32'hFFFF_FFFF / 32'd7 / 32'd32768);
    queue_word(KIND_RATE, 32'hFFFF_FFFF / 32'd7 / 32'd32768 + 32'd1);
    queue_word(KIND_RATE, 32'hFFFF_FFFF / 32'd5 / 32'd6);
    queue_word(KIND_RATE, 32'hFFFF_FFFF);
    queue_word(KIND_DRAIN, 32'd0);
    queue_word(KIND_CLOCK, 32'd1);
    queue_word(KIND_RATE, 32'd1);
    queue_word(KIND_CLOCK, 32'd0);
    queue_word(KIND_RATE, 32'd5);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       clk_set = $urandom;
        1:       clk_set = $urandom_range(1, 5000);
        2:       clk_set = 32'd1_000_000 * $urandom_range(8, 160);
        default: clk_set = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      queue_word(KIND_CLOCK, clk_set);
      n = $urandom_range(60, 90);
      for (int i = 0; i < n; i++) begin
        queue_word(KIND_RATE, pick_rate(clk_set));
        if (i == n / 2) queue_word(KIND_DRAIN, 32'd0);
      end
    end

    wait (request_q.size() == 0 && !start && !cfg_valid_i && outstanding <= 0);
    repeat (80) @(posedge clk_i);
    if (expected_divider_q.size() != 0) begin
      errors += expected_divider_q.size();
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, expected_divider_q.size());
    end
    $display("Searched %0d rates over %0d clock settings: %0d found, %0d zero, %0d unmatched.",
             rates_sent, clock_writes, found_cnt, invalid_cnt, no_match_cnt);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
